>>> hw/rtl/bfm_pkg.sv
// ----------------------------------------------------------------------------
// bfm_pkg
// Shared constants, types and helpers of the Bloom filter membership block.
// ----------------------------------------------------------------------------
package bfm_pkg;

    // default geometry
    localparam int BLOOM_BITS_DEF = 65536;
    localparam int MAX_HASHES_DEF = 16;

    // hash constants
    localparam logic [31:0] SEED_STEP = 32'h9e3779b9;
    localparam logic [31:0] MIX_C1    = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2    = 32'h1b873593;
    localparam logic [31:0] MIX_ADD   = 32'he6546b64;
    localparam logic [31:0] FIN_C1    = 32'h85ebca6b;
    localparam logic [31:0] FIN_C2    = 32'hc2b2ae35;

    // register reset values
    localparam logic [16:0] BIT_COUNT_RST  = 17'd65536;
    localparam logic [4:0]  HASH_COUNT_RST = 5'd7;

    // configuration register indexes
    localparam logic [7:0] REG_BIT_COUNT  = 8'd0;
    localparam logic [7:0] REG_HASH_COUNT = 8'd1;

    // request functions
    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_QUERY  = 2'd1;
    localparam logic [1:0] FN_CLEAR  = 2'd2;
    localparam logic [1:0] FN_NONE   = 2'd3;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_SC0,
        S_SC1,
        S_MRD,
        S_MWR,
        S_FRD,
        S_F1,
        S_F2,
        S_F3,
        S_DIV,
        S_SRD,
        S_SCHK
    } t_state;

    // seed of a lane: index times the golden ratio step, mod 2^32
    function automatic logic [31:0] f_seed(input logic [5:0] idx);
        logic [37:0] p;
        p = {32'd0, idx} * {6'd0, SEED_STEP};
        return p[31:0];
    endfunction

endpackage

>>> hw/rtl/bfm_mod.sv
// ----------------------------------------------------------------------------
// bfm_mod
// Restoring remainder unit: 32-bit dividend modulo a narrow divisor,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bfm_mod #(
    parameter int MW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [31:0]   i_num,
    input  logic [MW-1:0] i_den,
    output logic          o_done,
    output logic [MW-1:0] o_rem
);

    logic          r_busy;
    logic [4:0]    r_cnt;
    logic [31:0]   r_num;
    logic [MW-1:0] r_rem;
    logic          r_done;
    logic [MW:0]   trial;
    logic [MW:0]   diff;

    // shift in the next dividend bit and subtract when it fits
    assign trial = {r_rem, r_num[31]};
    assign diff  = trial - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_num;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[30:0], 1'b0};
                if (trial >= {1'b0, i_den}) begin
                    r_rem <= diff[MW-1:0];
                end else begin
                    r_rem <= trial[MW-1:0];
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> hw/rtl/bloom_filter_murmur_membership_top.sv
// ----------------------------------------------------------------------------
// bloom_filter_murmur_membership_top
// Bloom filter over a word-wide bit store, keys hashed by seeded
// MurmurHash3 x86_32 lanes.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; one key byte per
// request. A byte completing a 4-byte block is scrambled, then each of the
// MAX_HASHES lanes is read and written in the lane memory. At key end a
// partial tail is scrambled, then each of the hash_count lanes is read,
// finished by the fmix multiplies and reduced in the remainder unit, and its
// bit in the bit store is read and then checked or written. A clear, and
// reset, sweep the bit store one word a cycle with busy high. A result is
// shown on the o_ ports for one cycle with o_done high; the receiver cannot
// hold it off. Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module bloom_filter_murmur_membership_top
    import bfm_pkg::*;
#(
    parameter int BLOOM_BITS = BLOOM_BITS_DEF,
    parameter int MAX_HASHES = MAX_HASHES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_key_byte,
    input  logic        i_has_byte,
    input  logic        i_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_done,
    output logic        o_found,
    output logic [31:0] o_inserted_count,
    output logic [1:0]  o_done_op
);

    localparam int STORE_WORDS = (BLOOM_BITS + 63) / 64;
    localparam int AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int MW = $clog2(BLOOM_BITS + 1);
    localparam int LW = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
    localparam int HW = $clog2(MAX_HASHES + 1);

    // configuration
    logic [16:0] r_bit_count;
    logic [4:0]  r_hash_count;

    // control and key state
    t_state        r_state, n_state;
    logic [31:0]   r_tail, n_tail;
    logic [31:0]   r_len, n_len;
    logic          r_fresh, n_fresh;
    logic          r_fin, n_fin;
    logic          r_last, n_last;
    logic [1:0]    r_func, n_func;
    logic [31:0]   r_t, n_t;
    logic [31:0]   r_k, n_k;
    logic [31:0]   r_h, n_h;
    logic [LW-1:0] r_idx, n_idx;
    logic          r_found, n_found;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic          r_clr_res, n_clr_res;
    logic [31:0]   r_total, n_total;
    logic          r_done, n_done;
    logic          r_out_found, n_out_found;
    logic [1:0]    r_out_op, n_out_op;

    // memories
    logic [31:0] lane_mem [MAX_HASHES];
    logic [31:0] r_lane_q;
    logic [63:0] store_mem [STORE_WORDS];
    logic [63:0] r_store_q;
    logic          lane_re, lane_we;
    logic [31:0]   lane_wd;
    logic          st_re, st_we;
    logic [AW-1:0] st_addr;
    logic [63:0]   st_wd;

    // remainder unit
    logic          div_start, div_done;
    logic [31:0]   div_num;
    logic [MW-1:0] div_rem;

    // saturated modulus and hash count
    logic [MW-1:0] m_sat;
    logic [HW-1:0] k_sat;
    always_comb begin
        if (r_bit_count < 17'd64) begin
            m_sat = MW'(64);
        end else if (32'(r_bit_count) > 32'(BLOOM_BITS)) begin
            m_sat = MW'(BLOOM_BITS);
        end else begin
            m_sat = MW'(r_bit_count);
        end
        if (r_hash_count == 5'd0) begin
            k_sat = HW'(1);
        end else if (32'(r_hash_count) > 32'(MAX_HASHES)) begin
            k_sat = HW'(MAX_HASHES);
        end else begin
            k_sat = HW'(r_hash_count);
        end
    end

    // configuration write port
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_count  <= BIT_COUNT_RST;
            r_hash_count <= HASH_COUNT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_BIT_COUNT:  r_bit_count  <= i_cfg_data[16:0];
                REG_HASH_COUNT: r_hash_count <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // lane memory, registered read
    always_ff @(posedge i_clk) begin
        if (lane_we) begin
            lane_mem[r_idx] <= lane_wd;
        end
        if (lane_re) begin
            r_lane_q <= lane_mem[r_idx];
        end
    end

    // bit store, registered read
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            store_mem[st_addr] <= st_wd;
        end
        if (st_re) begin
            r_store_q <= store_mem[st_addr];
        end
    end

    bfm_mod #(.MW(MW)) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (m_sat),
        .o_done  (div_done),
        .o_rem   (div_rem)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_tail      <= '0;
            r_len       <= '0;
            r_fresh     <= 1'b1;
            r_fin       <= 1'b0;
            r_last      <= 1'b0;
            r_func      <= FN_INSERT;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_clr_addr  <= '0;
            r_clr_res   <= 1'b0;
            r_total     <= '0;
            r_done      <= 1'b0;
            r_out_found <= 1'b0;
            r_out_op    <= FN_INSERT;
        end else begin
            r_state     <= n_state;
            r_tail      <= n_tail;
            r_len       <= n_len;
            r_fresh     <= n_fresh;
            r_fin       <= n_fin;
            r_last      <= n_last;
            r_func      <= n_func;
            r_idx       <= n_idx;
            r_found     <= n_found;
            r_clr_addr  <= n_clr_addr;
            r_clr_res   <= n_clr_res;
            r_total     <= n_total;
            r_done      <= n_done;
            r_out_found <= n_out_found;
            r_out_op    <= n_out_op;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_t <= n_t;
        r_k <= n_k;
        r_h <= n_h;
    end

    // next state and datapath
    logic [31:0] lane_v;
    logic [31:0] h0, h1, rot;
    logic [63:0] bit_mask;
    logic        lane_last;
    assign lane_v    = r_fresh ? f_seed(6'(r_idx)) : r_lane_q;
    assign bit_mask  = 64'd1 << div_rem[5:0];
    assign lane_last = (HW'(r_idx) == k_sat - HW'(1));

    always_comb begin
        n_state     = r_state;
        n_tail      = r_tail;
        n_len       = r_len;
        n_fresh     = r_fresh;
        n_fin       = r_fin;
        n_last      = r_last;
        n_func      = r_func;
        n_t         = r_t;
        n_k         = r_k;
        n_h         = r_h;
        n_idx       = r_idx;
        n_found     = r_found;
        n_clr_addr  = r_clr_addr;
        n_clr_res   = r_clr_res;
        n_total     = r_total;
        n_done      = 1'b0;
        n_out_found = r_out_found;
        n_out_op    = r_out_op;
        lane_re     = 1'b0;
        lane_we     = 1'b0;
        lane_wd     = '0;
        st_re       = 1'b0;
        st_we       = 1'b0;
        st_addr     = AW'(div_rem >> 6);
        st_wd       = '0;
        div_start   = 1'b0;
        div_num     = '0;
        h0          = '0;
        h1          = '0;
        rot         = '0;

        unique case (r_state)
            // zero the bit store one word a cycle
            S_CLR: begin
                st_we   = 1'b1;
                st_addr = r_clr_addr;
                st_wd   = '0;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(STORE_WORDS - 1)) begin
                    n_clr_addr = '0;
                    n_state    = S_IDLE;
                    if (r_clr_res) begin
                        n_done      = 1'b1;
                        n_out_found = 1'b0;
                        n_out_op    = FN_CLEAR;
                        n_clr_res   = 1'b0;
                    end
                end
            end

            // take a request
            S_IDLE: begin
                if (start) begin
                    case (i_func) inside
                        FN_CLEAR: begin
                            n_total   = '0;
                            n_tail    = '0;
                            n_len     = '0;
                            n_fresh   = 1'b1;
                            n_clr_res = 1'b1;
                            n_state   = S_CLR;
                        end
                        FN_INSERT, FN_QUERY: begin
                            n_func  = i_func;
                            n_last  = i_last;
                            n_found = 1'b1;
                            n_idx   = '0;
                            if (i_has_byte) begin
                                n_tail = r_tail
                                       | (32'(i_key_byte) << {r_len[1:0], 3'b000});
                                n_len  = r_len + 32'd1;
                            end
                            if (i_has_byte && r_len[1:0] == 2'd3) begin
                                n_fin   = 1'b0;
                                n_state = S_SC0;
                            end else if (i_last) begin
                                n_fin   = 1'b1;
                                n_state = (n_len[1:0] != 2'd0) ? S_SC0 : S_FRD;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // scramble the tail word: two multiplies
            S_SC0: begin
                n_t     = r_tail * MIX_C1;
                n_state = S_SC1;
            end
            S_SC1: begin
                n_k     = {r_t[16:0], r_t[31:17]} * MIX_C2;
                n_state = r_fin ? S_FRD : S_MRD;
            end

            // mix a block into every lane
            S_MRD: begin
                lane_re = 1'b1;
                n_state = S_MWR;
            end
            S_MWR: begin
                h0      = lane_v ^ r_k;
                rot     = {h0[18:0], h0[31:19]};
                lane_wd = (rot << 2) + rot + MIX_ADD;
                lane_we = 1'b1;
                if (r_idx == LW'(MAX_HASHES - 1)) begin
                    n_idx   = '0;
                    n_tail  = '0;
                    n_fresh = 1'b0;
                    if (r_last) begin
                        n_fin   = 1'b1;
                        n_state = S_FRD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_idx   = r_idx + LW'(1);
                    n_state = S_MRD;
                end
            end

            // finish one lane
            S_FRD: begin
                lane_re = 1'b1;
                n_state = S_F1;
            end
            S_F1: begin
                h0 = lane_v ^ ((r_len[1:0] != 2'd0) ? r_k : 32'd0) ^ r_len;
                h1 = h0 ^ (h0 >> 16);
                n_h     = h1 * FIN_C1;
                n_state = S_F2;
            end
            S_F2: begin
                h1 = r_h ^ (r_h >> 13);
                n_h     = h1 * FIN_C2;
                n_state = S_F3;
            end
            S_F3: begin
                div_num   = r_h ^ (r_h >> 16);
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_SRD;
                end
            end

            // probe or set the picked bit
            S_SRD: begin
                st_re   = 1'b1;
                n_state = S_SCHK;
            end
            S_SCHK: begin
                if (r_func == FN_INSERT) begin
                    st_we = 1'b1;
                    st_wd = r_store_q | bit_mask;
                end else if ((r_store_q & bit_mask) == 64'd0) begin
                    n_found = 1'b0;
                end
                if (lane_last) begin
                    n_done   = 1'b1;
                    n_out_op = r_func;
                    if (r_func == FN_INSERT) begin
                        n_total     = r_total + 32'd1;
                        n_out_found = 1'b0;
                    end else begin
                        n_out_found = n_found;
                    end
                    n_idx   = '0;
                    n_tail  = '0;
                    n_len   = '0;
                    n_fresh = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_idx   = r_idx + LW'(1);
                    n_state = S_FRD;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    assign busy             = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_found          = r_out_found;
    assign o_inserted_count = r_total;
    assign o_done_op        = r_out_op;

endmodule

>>> test/tb_bloom_filter_murmur_membership_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bloom_filter_murmur_membership_top
// Streams insert, query and clear requests into the Bloom filter block under
// a series of register settings. A scoreboard class predicts every result
// with its own MurmurHash3 lanes and bit store, and checks each o_done
// strobe against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_bloom_filter_murmur_membership_top;
    import bfm_pkg::*;

    localparam int STORE_WORDS = (BLOOM_BITS_DEF + 63) / 64;
    localparam int CYCLE_LIMIT = 10000000;

    typedef struct {
        logic        found;
        logic [31:0] count;
        logic [1:0]  op;
    } t_membership;

    // prediction of the filter and the queue of results it owes
    class bloom_scoreboard;
        bit [63:0]   store [STORE_WORDS];
        bit [31:0]   lanes [MAX_HASHES_DEF];
        bit [31:0]   tail_bytes;
        bit [31:0]   key_len;
        bit [31:0]   insert_total;
        bit [16:0]   bit_count_reg;
        bit [4:0]    hash_count_reg;
        t_membership owed [$];
        int          errors;

        function new();
            foreach (store[i]) store[i] = '0;
            insert_total   = '0;
            bit_count_reg  = BIT_COUNT_RST;
            hash_count_reg = HASH_COUNT_RST;
            errors         = 0;
            restart_key();
        endfunction

        function void restart_key();
            foreach (lanes[i]) lanes[i] = 32'(i) * SEED_STEP;
            tail_bytes = '0;
            key_len    = '0;
        endfunction

        function bit [31:0] rotl(bit [31:0] x, int r);
            return (x << r) | (x >> (32 - r));
        endfunction

        function bit [31:0] scramble(bit [31:0] k);
            k = k * MIX_C1;
            k = rotl(k, 15);
            return k * MIX_C2;
        endfunction

        function void take_byte(bit [7:0] b);
            bit [1:0]  pos;
            bit [31:0] k;
            bit [31:0] h;
            pos = key_len[1:0];
            tail_bytes |= 32'(b) << (8 * pos);
            key_len++;
            if (pos == 2'd3) begin
                k = scramble(tail_bytes);
                foreach (lanes[i]) begin
                    h = rotl(lanes[i] ^ k, 13);
                    lanes[i] = h * 32'd5 + MIX_ADD;
                end
                tail_bytes = '0;
            end
        endfunction

        function bit [31:0] finish_lane(bit [31:0] h);
            if (key_len[1:0] != 2'd0) h ^= scramble(tail_bytes);
            h ^= key_len;
            h ^= h >> 16;
            h = h * FIN_C1;
            h ^= h >> 13;
            h = h * FIN_C2;
            h ^= h >> 16;
            return h;
        endfunction

        function void write_reg(bit [7:0] idx, bit [31:0] data);
            if (idx == REG_BIT_COUNT) bit_count_reg = data[16:0];
            else if (idx == REG_HASH_COUNT) hash_count_reg = data[4:0];
        endfunction

        // an accepted request: update the model and queue any result
        function void note_request(bit [1:0] fn, bit [7:0] b, bit has, bit last);
            bit [31:0]   m;
            bit [31:0]   kk;
            bit [31:0]   p;
            bit          hit;
            t_membership r;
            hit = 1'b1;
            if (fn == FN_NONE) return;
            if (fn == FN_CLEAR) begin
                foreach (store[i]) store[i] = '0;
                insert_total = '0;
                restart_key();
                r.found = 1'b0;
                r.count = '0;
                r.op    = FN_CLEAR;
                owed.push_back(r);
                return;
            end
            if (has) take_byte(b);
            if (!last) return;
            m  = bit_count_reg;
            if (m < 64) m = 64;
            if (m > BLOOM_BITS_DEF) m = BLOOM_BITS_DEF;
            kk = hash_count_reg;
            if (kk < 1) kk = 1;
            if (kk > MAX_HASHES_DEF) kk = MAX_HASHES_DEF;
            for (int i = 0; i < kk; i++) begin
                p = finish_lane(lanes[i]) % m;
                if (fn == FN_INSERT) store[(p >> 6) % STORE_WORDS][p[5:0]] = 1'b1;
                else if (!store[(p >> 6) % STORE_WORDS][p[5:0]]) hit = 1'b0;
            end
            if (fn == FN_INSERT) begin
                insert_total++;
                hit = 1'b0;
            end
            restart_key();
            r.found = hit;
            r.count = insert_total;
            r.op    = fn;
            owed.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic found, logic [31:0] count, logic [1:0] op);
            t_membership e;
            if (owed.size() == 0) begin
                report($sformatf("unexpected result op=%0d count=%0d", op, count));
                return;
            end
            e = owed.pop_front();
            if (found !== e.found)
                report($sformatf("found %b, want %b (op %0d)", found, e.found, e.op));
            if (count !== e.count)
                report($sformatf("inserted_count %0d, want %0d", count, e.count));
            if (op !== e.op)
                report($sformatf("done_op %0d, want %0d", op, e.op));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_func = FN_INSERT;
    logic [7:0]  i_key_byte = '0;
    logic        i_has_byte = 1'b0;
    logic        i_last = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        o_done;
    logic        o_found;
    logic [31:0] o_inserted_count;
    logic [1:0]  o_done_op;

    bloom_scoreboard sb = new();
    int  n_items = 0;
    int  cycles = 0;
    bit  idling = 1'b1;

    bloom_filter_murmur_membership_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_key_byte(i_key_byte), .i_has_byte(i_has_byte),
        .i_last(i_last), .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data), .o_done(o_done),
        .o_found(o_found), .o_inserted_count(o_inserted_count), .o_done_op(o_done_op)
    );

    always #5 i_clk = ~i_clk;

    // result monitor
    always @(posedge i_clk) begin
        if (o_done) sb.check_result(o_found, o_inserted_count, o_done_op);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // one request; start stays high into the next call unless a gap is drawn
    task send(bit [1:0] fn, bit [7:0] b, bit has, bit last);
        int gap;
        gap = (idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start      = 1'b1;
        i_func     = fn;
        i_key_byte = b;
        i_has_byte = has;
        i_last     = last;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        sb.note_request(fn, b, has, last);
        if (fn != FN_NONE) n_items++;
    endtask

    // stop sending and let every owed result arrive and the block go idle
    task drain();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        do @(posedge i_clk); while (busy);
        repeat (50) @(posedge i_clk);
    endtask

    task write_reg(bit [7:0] idx, bit [31:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // byte j of pooled key id; ids repeat so queries often hit
    function bit [7:0] pool_byte(int id, int j);
        return 8'(id * 37 + j * 101 + id * j + 5);
    endfunction

    // one key; pooled or random content, occasional noise, mixed func or clear
    task send_key(bit [1:0] fn, int len, int id);
        bit [7:0] b;
        bit [1:0] f;
        for (int j = 0; j < len; j++) begin
            b = (id >= 0) ? pool_byte(id, j) : 8'($urandom_range(0, 255));
            f = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 1)) : fn;
            if ($urandom_range(0, 11) == 0) send(f, 8'($urandom), 1'b0, 1'b0);
            if ($urandom_range(0, 15) == 0) send(FN_NONE, 8'($urandom), 1'($urandom),
                                                1'($urandom));
            if ($urandom_range(0, 59) == 0) begin
                send(FN_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom));
                return;
            end
            if (j == len - 1 && $urandom_range(0, 4) != 0) begin
                send(fn, b, 1'b1, 1'b1);
                return;
            end
            send(f, b, 1'b1, 1'b0);
        end
        send(fn, 8'($urandom), 1'b0, 1'b1);
    endtask

    initial begin
        bit [31:0] bc [8];
        bit [31:0] hc [8];
        int        id;
        int        len;
        bc = '{32'd65536, 32'd64, 32'd64, 32'h7ffe_0000, 32'hffff_ffff, 32'd1000, 32'd0, 32'd0};
        hc = '{32'd7, 32'd1, 32'd16, 32'h0000_0fe0, 32'hffff_ffff, 32'd3, 32'd0, 32'd0};
        bc[6] = $urandom_range(64, 65536);
        hc[6] = $urandom_range(1, 16);
        bc[7] = $urandom_range(64, 4096);
        hc[7] = $urandom_range(1, 16);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        drain();

        // directed: empty keys, extreme bytes, hit after insert, clear, ignored func
        send(FN_QUERY, 8'h00, 1'b0, 1'b1);
        send(FN_INSERT, 8'h00, 1'b0, 1'b1);
        send(FN_QUERY, 8'hff, 1'b0, 1'b1);
        send(FN_INSERT, 8'hff, 1'b1, 1'b0);
        send(FN_INSERT, 8'h00, 1'b1, 1'b0);
        send(FN_INSERT, 8'hff, 1'b1, 1'b0);
        send(FN_INSERT, 8'h00, 1'b1, 1'b1);
        send(FN_QUERY, 8'hff, 1'b1, 1'b0);
        send(FN_QUERY, 8'h00, 1'b1, 1'b0);
        send(FN_INSERT, 8'hff, 1'b1, 1'b0);
        send(FN_QUERY, 8'h00, 1'b1, 1'b1);
        send(FN_NONE, 8'hff, 1'b1, 1'b1);
        send(FN_INSERT, 8'ha5, 1'b1, 1'b0);
        send(FN_QUERY, 8'h5a, 1'b0, 1'b0);
        send(FN_QUERY, 8'h3c, 1'b1, 1'b1);
        send(FN_INSERT, 8'h11, 1'b1, 1'b0);
        send(FN_CLEAR, 8'hff, 1'b1, 1'b0);
        send(FN_QUERY, 8'h00, 1'b0, 1'b1);
        send(FN_CLEAR, 8'h00, 1'b0, 1'b1);
        send(FN_INSERT, 8'h01, 1'b1, 1'b1);
        send(FN_QUERY, 8'h01, 1'b1, 1'b1);
        drain();

        // random phases, one register setting each, last phase without gaps
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_BIT_COUNT, bc[ph]);
            write_reg(REG_HASH_COUNT, hc[ph]);
            if (ph == 7) idling = 1'b0;
            while (n_items < 21 + (ph + 1) * 235) begin
                id  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) : -1;
                len = (id >= 0) ? id % 9 + ((id > 12) ? 15 : 0)
                                : (($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                               : $urandom_range(0, 8));
                send_key(2'($urandom_range(0, 1)), len, id);
                if (idling && $urandom_range(0, 99) == 0) drain();
            end
            drain();
        end

        repeat (1100) @(posedge i_clk);
        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
